/* hw/rtl/mbb_pkg.sv */
// Shared types and constants for the bitmap blit stream block.
package mbb_pkg;

  // Panel size defaults
  localparam int PanelWidthDef  = 240;
  localparam int PanelHeightDef = 240;

  // Lanes: one per pixel of a bitmap byte
  localparam int NumLanes = 8;

  // Job buffer: up to two bytes per lane
  localparam int JobSlots = 2 * NumLanes;
  localparam int IdxW     = $clog2(JobSlots);
  localparam int CntW     = $clog2(JobSlots + 1);

  // Panel commands
  localparam logic [7:0] CMD_COLUMN_SET   = 8'h2A;
  localparam logic [7:0] CMD_ROW_SET      = 8'h2B;
  localparam logic [7:0] CMD_MEMORY_WRITE = 8'h2C;

  // Window command sequence length
  localparam logic [CntW-1:0] START_LEN = CntW'(11);

  // Input action codes
  localparam logic ACT_START  = 1'b0;
  localparam logic ACT_BITMAP = 1'b1;

  // Register indexes
  localparam logic [2:0] REG_WIN_X      = 3'd0;
  localparam logic [2:0] REG_WIN_Y      = 3'd1;
  localparam logic [2:0] REG_WIN_WIDTH  = 3'd2;
  localparam logic [2:0] REG_WIN_HEIGHT = 3'd3;
  localparam logic [2:0] REG_FG_COLOR   = 3'd4;
  localparam logic [2:0] REG_BG_COLOR   = 3'd5;
  localparam logic [2:0] REG_ROW_OFFSET = 3'd6;

  // One burst of output bytes produced by one input item
  typedef struct packed {
    logic [JobSlots-1:0][7:0] bytes;
    logic [JobSlots-1:0]      is_data;
    logic [CntW-1:0]          count;
  } job_t;

endpackage

/* hw/rtl/mono_bitmap_blit_lcd_stream_top.sv */
// Top level of the one-bit bitmap blitter with command/data byte stream output.
// Usage: write the window, colors and row offset through the cfg port while the
// block is idle, then send a start item (tuser 0) followed by bitmap items
// (tuser 1, tdata = eight pixels, bit 7 leftmost, each row starting on a fresh
// item). A start whose window fits the panel yields 11 bytes (column-set,
// row-set with offset, memory write); a bitmap item yields two bytes per pixel
// still inside the current row, up to 16. Output tuser is the data/command
// level, tlast marks the final byte of one input item. Items that cause no
// bytes (rejected start, item while idle, row already full) produce nothing.
// Rate: input is accepted into a one-deep job register while the previous item
// is still draining; the output serializer sends one byte per cycle while
// m_axis_tready is high. The serializer's single byte port sets that rate.
module mono_bitmap_blit_lcd_stream_top #(
  parameter int PANEL_WIDTH  = mbb_pkg::PanelWidthDef,
  parameter int PANEL_HEIGHT = mbb_pkg::PanelHeightDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // bits[7:0]
  input  logic        s_axis_tuser,   // action
  // output items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // byte_value[7:0]
  output logic        m_axis_tuser,   // is_data
  output logic        m_axis_tlast,   // last
  // register writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  localparam int NL = mbb_pkg::NumLanes;

  // Configuration registers
  logic [7:0]  win_x_q, win_y_q, win_width_q, win_height_q;
  logic [15:0] fg_color_q, bg_color_q;
  logic [6:0]  row_offset_q;

  // Blit state
  logic        active_q, active_d;
  logic [7:0]  col_q, col_d;
  logic [7:0]  row_q, row_d;

  // Job register between the input side and the serializer
  mbb_pkg::job_t job_q, job_d;
  logic          job_valid_q, job_valid_d;
  logic          job_ready;

  logic          in_fire;
  logic          fits;
  logic [8:0]    x_end, y_end;
  logic [15:0]   x0, x1, y0, y1;
  logic [7:0]    remaining;
  logic [3:0]    pixels;
  logic [7:0]    col_sum;
  logic [7:0]    row_inc;
  logic [15:0]   lane_color [NL];

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !job_valid_q || job_ready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // Register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_x_q      <= 8'd0;
      win_y_q      <= 8'd0;
      win_width_q  <= 8'd1;
      win_height_q <= 8'd1;
      fg_color_q   <= 16'hFFFF;
      bg_color_q   <= 16'h0000;
      row_offset_q <= 7'd80;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        mbb_pkg::REG_WIN_X:      win_x_q      <= cfg_data_i[7:0];
        mbb_pkg::REG_WIN_Y:      win_y_q      <= cfg_data_i[7:0];
        mbb_pkg::REG_WIN_WIDTH:  win_width_q  <= cfg_data_i[7:0];
        mbb_pkg::REG_WIN_HEIGHT: win_height_q <= cfg_data_i[7:0];
        mbb_pkg::REG_FG_COLOR:   fg_color_q   <= cfg_data_i;
        mbb_pkg::REG_BG_COLOR:   bg_color_q   <= cfg_data_i;
        mbb_pkg::REG_ROW_OFFSET: row_offset_q <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // Window check and coordinates
  assign x_end = {1'b0, win_x_q} + {1'b0, win_width_q};
  assign y_end = {1'b0, win_y_q} + {1'b0, win_height_q};
  assign fits  = (win_width_q != 8'd0) && (win_height_q != 8'd0) &&
                 (x_end <= 9'(PANEL_WIDTH)) && (y_end <= 9'(PANEL_HEIGHT));
  assign x0 = {8'd0, win_x_q};
  assign x1 = {7'd0, x_end} - 16'd1;
  assign y0 = {8'd0, win_y_q} + {9'd0, row_offset_q};
  assign y1 = {7'd0, y_end} - 16'd1 + {9'd0, row_offset_q};

  // Pixels left in the current row, capped at one byte's worth
  assign remaining = (win_width_q > col_q) ? (win_width_q - col_q) : 8'd0;
  assign pixels    = (remaining < 8'd8) ? remaining[3:0] : 4'd8;
  assign col_sum   = col_q + {4'd0, pixels};
  assign row_inc   = row_q + 8'd1;

  // Pixel lanes, lane 0 takes the leftmost bit
  for (genvar g = 0; g < NL; g++) begin : g_lane
    mbb_lane u_lane (
      .pix_i      (s_axis_tdata[NL-1-g]),
      .fg_color_i (fg_color_q),
      .bg_color_i (bg_color_q),
      .color_o    (lane_color[g])
    );
  end

  // Item handling: state update and job build happen on acceptance
  always_comb begin
    active_d    = active_q;
    col_d       = col_q;
    row_d       = row_q;
    job_d       = job_q;
    job_valid_d = job_valid_q && !job_ready;
    if (in_fire) begin
      if (s_axis_tuser == mbb_pkg::ACT_START) begin
        if (fits) begin
          active_d         = 1'b1;
          col_d            = 8'd0;
          row_d            = 8'd0;
          job_d            = '0;
          job_d.count      = mbb_pkg::START_LEN;
          job_d.bytes[0]   = mbb_pkg::CMD_COLUMN_SET;
          job_d.bytes[1]   = x0[15:8];
          job_d.bytes[2]   = x0[7:0];
          job_d.bytes[3]   = x1[15:8];
          job_d.bytes[4]   = x1[7:0];
          job_d.bytes[5]   = mbb_pkg::CMD_ROW_SET;
          job_d.bytes[6]   = y0[15:8];
          job_d.bytes[7]   = y0[7:0];
          job_d.bytes[8]   = y1[15:8];
          job_d.bytes[9]   = y1[7:0];
          job_d.bytes[10]  = mbb_pkg::CMD_MEMORY_WRITE;
          job_d.is_data    = '1;
          job_d.is_data[0] = 1'b0;
          job_d.is_data[5] = 1'b0;
          job_d.is_data[10] = 1'b0;
          job_valid_d      = 1'b1;
        end else begin
          active_d = 1'b0;
        end
      end else if (active_q) begin
        // bitmap byte: merge lane colors, high byte first
        for (int i = 0; i < NL; i++) begin
          job_d.bytes[2*i]   = lane_color[i][15:8];
          job_d.bytes[2*i+1] = lane_color[i][7:0];
        end
        job_d.is_data = '1;
        job_d.count   = {pixels, 1'b0};
        job_valid_d   = (pixels != 4'd0);
        col_d         = col_sum;
        if (col_sum >= win_width_q) begin
          col_d = 8'd0;
          row_d = row_inc;
          if (row_inc >= win_height_q) begin
            active_d = 1'b0;
            row_d    = 8'd0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      col_q       <= 8'd0;
      row_q       <= 8'd0;
      job_valid_q <= 1'b0;
    end else begin
      active_q    <= active_d;
      col_q       <= col_d;
      row_q       <= row_d;
      job_valid_q <= job_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
  end

  mbb_merge u_merge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_valid_i   (job_valid_q),
    .job_ready_o   (job_ready),
    .job_i         (job_q),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

/* hw/rtl/mbb_lane.sv */
// One pixel lane: turns a bitmap bit into its RGB565 color.
module mbb_lane (
  input  logic        pix_i,
  input  logic [15:0] fg_color_i,
  input  logic [15:0] bg_color_i,
  output logic [15:0] color_o
);

  assign color_o = pix_i ? fg_color_i : bg_color_i;

endmodule

/* hw/rtl/mbb_merge.sv */
// Merge stage: holds one job and sends its bytes one per cycle while m_axis_tready is high.
module mbb_merge (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               job_valid_i,
  output logic               job_ready_o,
  input  mbb_pkg::job_t      job_i,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [7:0]         m_axis_tdata,   // byte_value
  output logic               m_axis_tuser,   // is_data
  output logic               m_axis_tlast
);

  mbb_pkg::job_t                  buf_q;
  logic                           busy_q, busy_d;
  logic [mbb_pkg::IdxW-1:0]       idx_q, idx_d;
  logic                           last_byte;
  logic                           fire;
  logic                           load;

  assign last_byte   = ({1'b0, idx_q} == (buf_q.count - mbb_pkg::CntW'(1)));
  assign fire        = busy_q && m_axis_tready;
  assign job_ready_o = !busy_q || (fire && last_byte);
  assign load        = job_valid_i && job_ready_o;

  assign m_axis_tvalid = busy_q;
  assign m_axis_tdata  = buf_q.bytes[idx_q];
  assign m_axis_tuser  = buf_q.is_data[idx_q];
  assign m_axis_tlast  = last_byte;

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    if (load) begin
      busy_d = 1'b1;
      idx_d  = '0;
    end else if (fire) begin
      if (last_byte) begin
        busy_d = 1'b0;
      end else begin
        idx_d = idx_q + mbb_pkg::IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      buf_q <= job_i;
    end
  end

endmodule

/* sim/mono_bitmap_blit_lcd_stream_top_test.sv */
// Self-checking testbench for the one-bit bitmap blitter with byte stream output.
`timescale 1ns / 1ps

module mono_bitmap_blit_lcd_stream_top_test;

  localparam int PanelW = mbb_pkg::PanelWidthDef;
  localparam int PanelH = mbb_pkg::PanelHeightDef;
  // Index past the register list; writes there must be ignored
  localparam logic [2:0] REG_UNUSED = 3'd7;
  localparam int NumRandItems = 246;
  // Idle cycles granted after the last expected byte before touching registers
  localparam int SettleCycles = 40;
  // Cycles without any handshake before the run is declared hung
  localparam int QuietLimit = 2000;
  localparam int MaxPrinted = 30;

  typedef struct {
    logic       act;
    logic [7:0] pix;
  } pix_item_t;

  typedef struct {
    logic       dc;
    logic [7:0] val;
    logic       last;
  } lcd_byte_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        s_axis_tuser = mbb_pkg::ACT_START;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = mbb_pkg::REG_WIN_X;
  logic [15:0] cfg_data_i = 16'h0000;

  mono_bitmap_blit_lcd_stream_top u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Items waiting for the driver, and bytes the panel link should carry
  pix_item_t pend_q[$];
  lcd_byte_t lcd_byte_q[$];
  int        n_items = 0;
  int        err_cnt = 0;

  // Register shadow, reset values
  logic [7:0]  cfg_x   = 8'd0;
  logic [7:0]  cfg_y   = 8'd0;
  logic [7:0]  cfg_w   = 8'd1;
  logic [7:0]  cfg_h   = 8'd1;
  logic [15:0] cfg_fg  = 16'hFFFF;
  logic [15:0] cfg_bg  = 16'h0000;
  logic [6:0]  cfg_off = 7'd80;

  // Blit progress shadow
  logic blit_on   = 1'b0;
  int   col_done  = 0;
  int   rows_done = 0;

  task automatic flag_mismatch(input string msg);
    err_cnt++;
    if (err_cnt <= MaxPrinted) begin
      $display("MISMATCH @%0t: %s", $realtime, msg);
    end
  endtask

  function automatic void push_byte(input logic dc, input logic [7:0] v);
    lcd_byte_t b;
    b.dc = dc;
    b.val = v;
    b.last = 1'b0;
    lcd_byte_q.push_back(b);
  endfunction

  // 16-bit value, big-endian, as two data bytes
  function automatic void push_word(input logic [15:0] w);
    push_byte(1'b1, w[15:8]);
    push_byte(1'b1, w[7:0]);
  endfunction

  // Works out the link bytes one accepted item causes and queues them
  function automatic void expand_item(input logic act, input logic [7:0] pix);
    int base;
    int room;
    int npix;
    base = lcd_byte_q.size();
    if (act == mbb_pkg::ACT_START) begin
      // Empty or off-panel window: nothing sent, any running blit dies
      if (cfg_w == 0 || cfg_h == 0 || int'(cfg_x) + int'(cfg_w) > PanelW ||
          int'(cfg_y) + int'(cfg_h) > PanelH) begin
        blit_on = 1'b0;
      end else begin
        push_byte(1'b0, mbb_pkg::CMD_COLUMN_SET);
        push_word(16'(int'(cfg_x)));
        push_word(16'(int'(cfg_x) + int'(cfg_w) - 1));
        push_byte(1'b0, mbb_pkg::CMD_ROW_SET);
        push_word(16'(int'(cfg_y) + int'(cfg_off)));
        push_word(16'(int'(cfg_y) + int'(cfg_h) - 1 + int'(cfg_off)));
        push_byte(1'b0, mbb_pkg::CMD_MEMORY_WRITE);
        blit_on = 1'b1;
        col_done = 0;
        rows_done = 0;
      end
    end else if (blit_on) begin
      // Pixels past the row width are padding; a shrunk width may leave none
      room = (int'(cfg_w) > col_done) ? int'(cfg_w) - col_done : 0;
      npix = (room < 8) ? room : 8;
      for (int i = 0; i < npix; i++) begin
        push_word(pix[7 - i] ? cfg_fg : cfg_bg);
      end
      col_done += npix;
      if (col_done >= int'(cfg_w)) begin
        col_done = 0;
        rows_done = (rows_done + 1) & 8'hFF;
        if (rows_done >= int'(cfg_h)) begin
          blit_on = 1'b0;
          rows_done = 0;
        end
      end
    end
    if (lcd_byte_q.size() > base) begin
      lcd_byte_q[lcd_byte_q.size() - 1].last = 1'b1;
    end
  endfunction

  // Driver: bursts of random length, random gaps between them
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= 8'h00;
      s_axis_tuser <= mbb_pkg::ACT_START;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expand_item(pend_q[0].act, pend_q[0].pix);
        void'(pend_q.pop_front());
      end
      if (s_axis_tvalid && !s_axis_tready) begin
        // hold the offered item
      end else if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (pend_q.size() > 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= pend_q[0].pix;
        s_axis_tuser <= pend_q[0].act;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: checks every byte, ready follows a rotating stall pattern
  logic [15:0] rdy_pat = 16'hFFFF;
  int          pat_age = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    lcd_byte_t e;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rdy_pat = 16'hFFFF;
      pat_age = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (lcd_byte_q.size() == 0) begin
          flag_mismatch($sformatf("unexpected byte %02h dc %0b", m_axis_tdata, m_axis_tuser));
        end else begin
          e = lcd_byte_q.pop_front();
          if (m_axis_tuser !== e.dc) begin
            flag_mismatch($sformatf("dc %b, want %b", m_axis_tuser, e.dc));
          end
          if (m_axis_tdata !== e.val) begin
            flag_mismatch($sformatf("byte %02h, want %02h", m_axis_tdata, e.val));
          end
          if (m_axis_tlast !== e.last) begin
            flag_mismatch($sformatf("last %b, want %b", m_axis_tlast, e.last));
          end
        end
      end
      pat_age++;
      if (pat_age == 64) begin
        pat_age = 0;
        case ($urandom_range(0, 4))
          0, 1: rdy_pat = 16'hFFFF;
          2: rdy_pat = 16'($urandom);
          3: rdy_pat = 16'h0001;      // long stalls
          default: rdy_pat = 16'hAAAA;
        endcase
      end else begin
        rdy_pat = {rdy_pat[0], rdy_pat[15:1]};
      end
      m_axis_tready <= rdy_pat[0];
    end
  end

  // Watchdog: too long without any handshake means the block hung
  int quiet_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles == QuietLimit) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      mbb_pkg::REG_WIN_X:      cfg_x = data[7:0];
      mbb_pkg::REG_WIN_Y:      cfg_y = data[7:0];
      mbb_pkg::REG_WIN_WIDTH:  cfg_w = data[7:0];
      mbb_pkg::REG_WIN_HEIGHT: cfg_h = data[7:0];
      mbb_pkg::REG_FG_COLOR:   cfg_fg = data;
      mbb_pkg::REG_BG_COLOR:   cfg_bg = data;
      mbb_pkg::REG_ROW_OFFSET: cfg_off = data[6:0];
      default: ;
    endcase
  endtask

  task automatic queue_item(input logic act, input logic [7:0] pix);
    pix_item_t it;
    it.act = act;
    it.pix = pix;
    pend_q.push_back(it);
    n_items++;
  endtask

  // Waits until the block has nothing left to deliver, then a little longer
  task automatic settle();
    while (pend_q.size() != 0 || s_axis_tvalid || lcd_byte_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic logic [7:0] rand_pix();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] rand_color();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    int mode;
    int w;
    int h;
    int x;
    int y;
    int nbytes;
    int stop_items;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset window: one pixel, bytes while idle are dropped
    queue_item(mbb_pkg::ACT_BITMAP, 8'hFF);
    queue_item(mbb_pkg::ACT_START, 8'h00);
    queue_item(mbb_pkg::ACT_BITMAP, 8'h80);
    queue_item(mbb_pkg::ACT_BITMAP, 8'h7F);
    settle();

    // Right edge window, offset masked to 7 bits, unused index ignored
    write_reg(mbb_pkg::REG_WIN_X, 16'hA5E8);
    write_reg(mbb_pkg::REG_WIN_Y, 16'h0000);
    write_reg(mbb_pkg::REG_WIN_WIDTH, 16'h0008);
    write_reg(mbb_pkg::REG_WIN_HEIGHT, 16'hFF02);
    write_reg(mbb_pkg::REG_FG_COLOR, 16'hA55A);
    write_reg(mbb_pkg::REG_BG_COLOR, 16'h1234);
    write_reg(mbb_pkg::REG_ROW_OFFSET, 16'hFFFF);
    write_reg(REG_UNUSED, 16'hBEEF);
    queue_item(mbb_pkg::ACT_START, 8'hFF);
    queue_item(mbb_pkg::ACT_BITMAP, 8'hFF);
    queue_item(mbb_pkg::ACT_BITMAP, 8'h00);
    queue_item(mbb_pkg::ACT_BITMAP, 8'h55);
    settle();

    // Window one column past the panel: start rejected
    write_reg(mbb_pkg::REG_WIN_X, 16'h00E9);
    queue_item(mbb_pkg::ACT_START, 8'h00);
    queue_item(mbb_pkg::ACT_BITMAP, 8'hFF);
    settle();

    // Zero width, then zero height
    write_reg(mbb_pkg::REG_WIN_X, 16'h0000);
    write_reg(mbb_pkg::REG_WIN_WIDTH, 16'h0000);
    queue_item(mbb_pkg::ACT_START, 8'h00);
    settle();
    write_reg(mbb_pkg::REG_WIN_WIDTH, 16'h00F0);
    write_reg(mbb_pkg::REG_WIN_HEIGHT, 16'h0000);
    queue_item(mbb_pkg::ACT_START, 8'h00);
    settle();

    // Full panel, restart in the middle of a blit
    write_reg(mbb_pkg::REG_WIN_HEIGHT, 16'h00F0);
    write_reg(mbb_pkg::REG_ROW_OFFSET, 16'h0000);
    queue_item(mbb_pkg::ACT_START, 8'h00);
    queue_item(mbb_pkg::ACT_BITMAP, 8'hC3);
    queue_item(mbb_pkg::ACT_BITMAP, 8'h3C);
    queue_item(mbb_pkg::ACT_START, 8'h00);
    queue_item(mbb_pkg::ACT_BITMAP, 8'hF0);
    settle();

    // Bottom overflow kills the running blit
    write_reg(mbb_pkg::REG_WIN_Y, 16'h0001);
    queue_item(mbb_pkg::ACT_START, 8'h00);
    queue_item(mbb_pkg::ACT_BITMAP, 8'hFF);
    settle();

    // Width shrinks below the pixels already sent in the row
    write_reg(mbb_pkg::REG_WIN_Y, 16'h000A);
    write_reg(mbb_pkg::REG_WIN_WIDTH, 16'h0014);
    write_reg(mbb_pkg::REG_WIN_HEIGHT, 16'h0002);
    write_reg(mbb_pkg::REG_ROW_OFFSET, 16'h0050);
    queue_item(mbb_pkg::ACT_START, 8'h00);
    queue_item(mbb_pkg::ACT_BITMAP, 8'hAA);
    settle();
    write_reg(mbb_pkg::REG_WIN_WIDTH, 16'h0005);
    queue_item(mbb_pkg::ACT_BITMAP, 8'hFF);
    queue_item(mbb_pkg::ACT_BITMAP, 8'h96);
    queue_item(mbb_pkg::ACT_BITMAP, 8'h01);
    settle();

    // Random phases: mostly complete blits, some wide, rejected or cut short
    stop_items = n_items + NumRandItems;
    while (n_items < stop_items) begin
      mode = $urandom_range(0, 9);
      w = $urandom_range(1, 24);
      h = $urandom_range(1, 4);
      x = $urandom_range(0, PanelW - w);
      y = $urandom_range(0, PanelH - h);
      if (mode == 0) begin
        w = $urandom_range(200, PanelW);
        h = 1;
        x = $urandom_range(0, PanelW - w);
        y = $urandom_range(0, PanelH - 1);
      end else if (mode == 1) begin
        case ($urandom_range(0, 3))
          0: w = 0;
          1: h = 0;
          2: begin
            x = $urandom_range(1, PanelW - 1);
            w = $urandom_range(PanelW + 1 - x, 255);
          end
          default: begin
            y = $urandom_range(1, PanelH - 1);
            h = $urandom_range(PanelH + 1 - y, 255);
          end
        endcase
      end else if ($urandom_range(0, 3) == 0) begin
        // bottom-right corner
        x = PanelW - w;
        y = PanelH - h;
      end
      write_reg(mbb_pkg::REG_WIN_X, {8'($urandom), 8'(x)});
      write_reg(mbb_pkg::REG_WIN_Y, {8'($urandom), 8'(y)});
      write_reg(mbb_pkg::REG_WIN_WIDTH, {8'($urandom), 8'(w)});
      write_reg(mbb_pkg::REG_WIN_HEIGHT, {8'($urandom), 8'(h)});
      if ($urandom_range(0, 1) == 0) write_reg(mbb_pkg::REG_FG_COLOR, rand_color());
      if ($urandom_range(0, 1) == 0) write_reg(mbb_pkg::REG_BG_COLOR, rand_color());
      if ($urandom_range(0, 2) == 0) write_reg(mbb_pkg::REG_ROW_OFFSET, rand_color());
      if ($urandom_range(0, 7) == 0) write_reg(REG_UNUSED, 16'($urandom));

      // Occasionally no start: bytes continue a blit left open, or are dropped
      if ($urandom_range(0, 9) != 0) queue_item(mbb_pkg::ACT_START, rand_pix());
      nbytes = (mode == 1) ? $urandom_range(1, 3) : ((w + 7) / 8) * h;
      if ($urandom_range(0, 7) == 0) nbytes = $urandom_range(0, nbytes);
      for (int i = 0; i < nbytes; i++) begin
        if ($urandom_range(0, 15) == 0) queue_item(1'($urandom_range(0, 1)), rand_pix());
        queue_item(mbb_pkg::ACT_BITMAP, rand_pix());
      end
      if ($urandom_range(0, 3) == 0) queue_item(mbb_pkg::ACT_BITMAP, rand_pix());
      settle();
    end

    if (err_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
